### hdl/bbc_pkg.sv
// Package for the binary image bounding box block.
// Holds field widths, default parameter values, register indexes and the scan result type.
// No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int PIX_W       = 8;
  localparam int IMG_WIDTH_W = 14;
  localparam int X_OUT_W     = 13;
  localparam int Y_OUT_W     = 12;

  // Default sizing of the bitmap.
  localparam int DEF_MAX_WIDTH = 8192;
  localparam int DEF_MAX_ROWS  = 4096;

  // Rows are padded to this many pixels in storage.
  localparam int ROW_PAD_PIX   = 32;
  localparam int ROW_PAD_SHIFT = 5;
  localparam int BYTE_SHIFT    = 3;

  // Configuration register map.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = IMG_WIDTH_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_MSB_FIRST   = 1'b1
  } bbc_reg_t;

  // Reset values of the configuration registers.
  localparam int RST_IMAGE_WIDTH = 240;
  localparam logic RST_MSB_FIRST = 1'b1;

  // Result of scanning one byte: whether any counted pixel is white, and the
  // offsets within the byte of the leftmost and rightmost white pixel.
  typedef struct packed {
    logic                  hit;
    logic [BYTE_SHIFT-1:0] first;
    logic [BYTE_SHIFT-1:0] last;
  } bbc_scan_t;

endpackage

### hdl/bbc_in_if.sv
// Input stream interface of the bounding box block: one pixel byte per transfer.
// Depends on bbc_pkg for the byte width.
`timescale 1ns / 1ps

interface bbc_in_if
  import bbc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  logic             frame_end;

  modport source (output valid, output pixel_byte, output frame_end, input ready);
  modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

### hdl/bbc_out_if.sv
// Result stream interface of the bounding box block: one box per frame.
// Depends on bbc_pkg for the coordinate widths.
`timescale 1ns / 1ps

interface bbc_out_if
  import bbc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [X_OUT_W-1:0] mid_x;
  logic [Y_OUT_W-1:0] mid_y;
  logic [X_OUT_W-1:0] box_x_min;
  logic [X_OUT_W-1:0] box_x_max;
  logic [Y_OUT_W-1:0] box_y_min;
  logic [Y_OUT_W-1:0] box_y_max;

  modport source (output valid, output found, output mid_x, output mid_y,
                  output box_x_min, output box_x_max, output box_y_min,
                  output box_y_max, input ready);
  modport sink   (input valid, input found, input mid_x, input mid_y,
                  input box_x_min, input box_x_max, input box_y_min,
                  input box_y_max, output ready);
endinterface

### hdl/bbc_pixel_scan.sv
// Combinational scan of one pixel byte: masks padding pixels and finds the
// leftmost and rightmost white pixel. Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_pixel_scan
  import bbc_pkg::*;
#(
  parameter int COL_W = 10,
  parameter int W_W   = 14
) (
  input  logic [PIX_W-1:0] pixel_byte,
  input  logic             msb_first,
  input  logic [COL_W-1:0] col,
  input  logic [W_W-1:0]   width,
  output bbc_scan_t        scan
);

  logic [PIX_W-1:0] mask;

  // Pixel k is the k-th from the left inside the byte.
  always_comb begin
    for (int k = 0; k < PIX_W; k++) begin
      mask[k] = (msb_first ? pixel_byte[PIX_W-1-k] : pixel_byte[k]) &&
                (32'({col, BYTE_SHIFT'(k)}) < 32'(width));
    end
  end

  always_comb begin
    scan.hit   = |mask;
    scan.first = '0;
    scan.last  = '0;
    for (int k = PIX_W - 1; k >= 0; k--) begin
      if (mask[k]) begin
        scan.first = BYTE_SHIFT'(k);
      end
    end
    for (int k = 0; k < PIX_W; k++) begin
      if (mask[k]) begin
        scan.last = BYTE_SHIFT'(k);
      end
    end
  end

endmodule

### hdl/bbc_box_track.sv
// Position counters and bounding box accumulators of the bounding box block.
// Depends on bbc_pkg for the scan result type.
`timescale 1ns / 1ps

module bbc_box_track
  import bbc_pkg::*;
#(
  parameter int COL_W = 10,
  parameter int X_W   = 13,
  parameter int R_W   = 12,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             frame_last,
  input  logic [COL_W-1:0] col_end,
  input  bbc_scan_t        scan,
  output logic [COL_W-1:0] col,
  output logic             upd_any,
  output logic [X_W-1:0]   upd_x_low,
  output logic [X_W-1:0]   upd_x_high,
  output logic [R_W-1:0]   upd_y_low,
  output logic [R_W-1:0]   upd_y_high
);

  localparam logic [R_W-1:0] ROW_LAST = R_W'(MAX_ROWS - 1);

  logic [R_W-1:0]   row;
  logic             any_white;
  logic [X_W-1:0]   x_low;
  logic [X_W-1:0]   x_high;
  logic [R_W-1:0]   y_low;
  logic [R_W-1:0]   y_high;
  logic [COL_W-1:0] col_next;
  logic [R_W-1:0]   row_next;
  logic [X_W-1:0]   byte_x_lo;
  logic [X_W-1:0]   byte_x_hi;

  assign byte_x_lo = {col, scan.first};
  assign byte_x_hi = {col, scan.last};

  always_comb begin
    upd_any    = any_white;
    upd_x_low  = x_low;
    upd_x_high = x_high;
    upd_y_low  = y_low;
    upd_y_high = y_high;
    if (scan.hit) begin
      upd_any = 1'b1;
      if (!any_white) begin
        upd_x_low  = byte_x_lo;
        upd_x_high = byte_x_hi;
        upd_y_low  = row;
        upd_y_high = row;
      end else begin
        if (byte_x_lo < x_low)  upd_x_low  = byte_x_lo;
        if (byte_x_hi > x_high) upd_x_high = byte_x_hi;
        if (row < y_low)        upd_y_low  = row;
        if (row > y_high)       upd_y_high = row;
      end
    end
  end

  // The row closes on the last byte of the padded stride, or at once when a
  // narrower width was written mid-row. The row count sticks at its top.
  always_comb begin
    col_next = col + COL_W'(1);
    row_next = row;
    if (col >= col_end) begin
      col_next = '0;
      if (row != ROW_LAST) begin
        row_next = row + R_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      any_white <= 1'b0;
      x_low     <= '0;
      x_high    <= '0;
      y_low     <= '0;
      y_high    <= '0;
    end else if (step) begin
      if (frame_last) begin
        col       <= '0;
        row       <= '0;
        any_white <= 1'b0;
        x_low     <= '0;
        x_high    <= '0;
        y_low     <= '0;
        y_high    <= '0;
      end else begin
        col       <= col_next;
        row       <= row_next;
        any_white <= upd_any;
        x_low     <= upd_x_low;
        x_high    <= upd_x_high;
        y_low     <= upd_y_low;
        y_high    <= upd_y_high;
      end
    end
  end

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_white |-> (x_low <= x_high) && (y_low <= y_high))
    else $error("bounding box corners out of order");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    !any_white |-> (x_low == '0) && (x_high == '0) && (y_low == '0) && (y_high == '0))
    else $error("empty box holds nonzero corners");

endmodule

### hdl/binary_image_bbox_center.sv
// Bounding box and center of the white pixels of a 1-bit bitmap stream.
// The transfer of a frame's last byte loads the input register; once that byte
// advances, the result register loads and then presents the box.
// Throughput: one pixel byte per cycle; a frame's last byte waits only while the
// previous result is still untaken. Reset (rst, synchronous, active high) clears the
// counters, the box and both registers, and sets image_width to 240 and msb_first to 1.
`timescale 1ns / 1ps

module binary_image_bbox_center
  import bbc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bbc_in_if.sink                pixels,
  bbc_out_if.source             result
);

  // Column positions cover the width rounded up to the 32-pixel row padding.
  localparam int PAD_WIDTH = ((MAX_WIDTH + ROW_PAD_PIX - 1) / ROW_PAD_PIX) * ROW_PAD_PIX;
  localparam int X_W       = $clog2(PAD_WIDTH);
  localparam int COL_W     = X_W - BYTE_SHIFT;
  localparam int R_W       = $clog2(MAX_ROWS);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int RST_EFF_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
  localparam int RST_COL_END =
    (((RST_EFF_W + ROW_PAD_PIX - 1) / ROW_PAD_PIX) * 4) - 1;

  // Configuration. The width is stored already clamped to 1..MAX_WIDTH,
  // along with the index of the last byte of a padded row, so that the
  // per-byte path sees no clamp or stride arithmetic.
  logic [W_W-1:0]   width;
  logic [COL_W-1:0] col_end;
  logic             msb_first;
  logic [31:0]      wr_width;
  logic [31:0]      wr_col_end;

  always_comb begin
    if (cfg_wdata == '0) begin
      wr_width = 32'd1;
    end else if (32'(cfg_wdata) > MAX_WIDTH) begin
      wr_width = 32'(MAX_WIDTH);
    end else begin
      wr_width = 32'(cfg_wdata);
    end
    // Bytes per padded row is the width in 32-pixel words times four.
    wr_col_end = (((wr_width + 32'(ROW_PAD_PIX - 1)) >> ROW_PAD_SHIFT) << 2) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= W_W'(RST_EFF_W);
      col_end   <= COL_W'(RST_COL_END);
      msb_first <= RST_MSB_FIRST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width   <= W_W'(wr_width);
          col_end <= COL_W'(wr_col_end);
        end
        REG_MSB_FIRST: begin
          msb_first <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register. A byte moves on unless it closes a frame while the
  // previous result still waits in the result register, so the input side
  // keeps taking bytes while a finished result is pending.
  logic             in_valid;
  logic [PIX_W-1:0] in_byte;
  logic             in_last;
  logic             advance;
  logic             out_valid;

  assign advance      = in_valid && (!in_last || !out_valid || result.ready);
  assign pixels.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixels.valid && pixels.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      in_byte <= pixels.pixel_byte;
      in_last <= pixels.frame_end;
    end
  end

  // Per-byte work: scan the byte, then fold it into the running box.
  bbc_scan_t        scan;
  logic [COL_W-1:0] col;
  logic             upd_any;
  logic [X_W-1:0]   upd_x_low;
  logic [X_W-1:0]   upd_x_high;
  logic [R_W-1:0]   upd_y_low;
  logic [R_W-1:0]   upd_y_high;

  bbc_pixel_scan #(
    .COL_W (COL_W),
    .W_W   (W_W)
  ) u_scan (
    .pixel_byte (in_byte),
    .msb_first  (msb_first),
    .col        (col),
    .width      (width),
    .scan       (scan)
  );

  bbc_box_track #(
    .COL_W    (COL_W),
    .X_W      (X_W),
    .R_W      (R_W),
    .MAX_ROWS (MAX_ROWS)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .frame_last (in_last),
    .col_end    (col_end),
    .scan       (scan),
    .col        (col),
    .upd_any    (upd_any),
    .upd_x_low  (upd_x_low),
    .upd_x_high (upd_x_high),
    .upd_y_low  (upd_y_low),
    .upd_y_high (upd_y_high)
  );

  // Center is the rounded-down midpoint; the sums carry one extra bit.
  logic [X_W:0] sum_x;
  logic [R_W:0] sum_y;

  assign sum_x = {1'b0, upd_x_low} + {1'b0, upd_x_high};
  assign sum_y = {1'b0, upd_y_low} + {1'b0, upd_y_high};

  // Result register. It loads when the frame's last byte advances and
  // empties on the transfer of the result.
  logic               res_found;
  logic [X_OUT_W-1:0] res_mid_x;
  logic [Y_OUT_W-1:0] res_mid_y;
  logic [X_OUT_W-1:0] res_x_min;
  logic [X_OUT_W-1:0] res_x_max;
  logic [Y_OUT_W-1:0] res_y_min;
  logic [Y_OUT_W-1:0] res_y_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // An empty frame reports all zeros; the accumulators already hold zeros
  // then, but the gate keeps that explicit.
  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res_found <= upd_any;
      res_mid_x <= upd_any ? X_OUT_W'(sum_x >> 1) : '0;
      res_mid_y <= upd_any ? Y_OUT_W'(sum_y >> 1) : '0;
      res_x_min <= upd_any ? X_OUT_W'(upd_x_low) : '0;
      res_x_max <= upd_any ? X_OUT_W'(upd_x_high) : '0;
      res_y_min <= upd_any ? Y_OUT_W'(upd_y_low) : '0;
      res_y_max <= upd_any ? Y_OUT_W'(upd_y_high) : '0;
    end
  end

  assign result.valid     = out_valid;
  assign result.found     = res_found;
  assign result.mid_x     = res_mid_x;
  assign result.mid_y     = res_mid_y;
  assign result.box_x_min = res_x_min;
  assign result.box_x_max = res_x_max;
  assign result.box_y_min = res_y_min;
  assign result.box_y_max = res_y_max;

  // A result only appears after a frame's last byte was folded in.
  a_result_from_frame_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_last))
    else $error("result raised without a frame end");

  // The input side only stalls behind a frame end blocked by a pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> in_valid && in_last && out_valid && !result.ready)
    else $error("input stalled without a blocked frame end");

  // A result without white pixels carries zeros throughout.
  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_found) |->
      (res_mid_x == '0) && (res_mid_y == '0) && (res_x_min == '0) &&
      (res_x_max == '0) && (res_y_min == '0) && (res_y_max == '0))
    else $error("empty frame result has nonzero fields");

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for binary_image_bbox_center: directed pixel rows, then random frames.
// Predicts every frame's bounding box and center and compares each result transfer by field.
// Depends on bbc_pkg, the bbc_in_if and bbc_out_if interfaces and the binary_image_bbox_center RTL.
`timescale 1ns / 1ps

module tb_top;
  import bbc_pkg::*;

  // The limit only catches a hung handshake.
  localparam int CYCLE_LIMIT  = 40000;
  // The directed rows send about 1080 bytes; the random part adds these.
  localparam int RANDOM_ITEMS = 770;
  // The receiver refuses results for this long once, so that the result
  // register stays full and the block has to back-pressure the pixel stream.
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_CYCLES = 600;
  // Margin for bytes still in the input register.
  localparam int DRAIN_CYCLES = 4;
  localparam int NUM_STEPS    = 20;

  // One bounding box result, laid out like the result interface.
  typedef struct packed {
    logic               found;
    logic [X_OUT_W-1:0] mid_x;
    logic [Y_OUT_W-1:0] mid_y;
    logic [X_OUT_W-1:0] box_x_min;
    logic [X_OUT_W-1:0] box_x_max;
    logic [Y_OUT_W-1:0] box_y_min;
    logic [Y_OUT_W-1:0] box_y_max;
  } box_t;

  localparam box_t NO_BOX = '0;

  // One row of the directed plan: an optional register update (done while the
  // block is idle), then the same byte sent reps times. frame_end goes with the
  // last of those bytes only if fin is set. Where fixed is set, the box typed
  // into the row is the expectation instead of the predicted one.
  typedef struct {
    bit               set_cfg;
    int               width;
    bit               msb;
    logic [PIX_W-1:0] pix;
    int               reps;
    bit               fin;
    bit               fixed;
    box_t             box;
  } step_t;

  logic clk;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bbc_in_if  pix_if ();
  bbc_out_if box_if ();

  binary_image_bbox_center dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixels    (pix_if),
    .result    (box_if)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [IMG_WIDTH_W-1:0] width_reg = IMG_WIDTH_W'(RST_IMAGE_WIDTH);
  bit                     msb_reg   = RST_MSB_FIRST;

  // Scan position and running box of the frame being received.
  int unsigned byte_col = 0;
  int unsigned row_num  = 0;
  int unsigned x_lo = 0;
  int unsigned x_hi = 0;
  int unsigned y_lo = 0;
  int unsigned y_hi = 0;
  bit          white_seen = 1'b0;

  // Boxes predicted for frames whose last byte has been accepted, oldest first.
  box_t boxes_due[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  sender_quiet = 1'b0;
  bit  holdoff_armed = 1'b0;

  // Directed plan. The first rows run at the reset configuration (240 pixels,
  // leftmost pixel in bit 7, 32 bytes per stored row).
  step_t plan [0:NUM_STEPS-1] = '{
    // A frame with no white pixel reports nothing but zeros.
    '{1'b0, 0, 1'b0, 8'h00, 1, 1'b1, 1'b1, NO_BOX},
    // Single pixels at both ends of a byte, then a full byte.
    '{1'b0, 0, 1'b0, 8'h80, 1, 1'b1, 1'b1, '{1'b1, 13'd0, 12'd0, 13'd0, 13'd0, 12'd0, 12'd0}},
    '{1'b0, 0, 1'b0, 8'h01, 1, 1'b1, 1'b1, '{1'b1, 13'd7, 12'd0, 13'd7, 13'd7, 12'd0, 12'd0}},
    '{1'b0, 0, 1'b0, 8'hFF, 1, 1'b1, 1'b1, '{1'b1, 13'd3, 12'd0, 13'd0, 13'd7, 12'd0, 12'd0}},
    // Leftmost pixel in bit 0.
    '{1'b1, 240, 1'b0, 8'h01, 1, 1'b1, 1'b1, '{1'b1, 13'd0, 12'd0, 13'd0, 13'd0, 12'd0, 12'd0}},
    '{1'b0, 0, 1'b0, 8'h80, 1, 1'b1, 1'b1, '{1'b1, 13'd7, 12'd0, 13'd7, 13'd7, 12'd0, 12'd0}},
    // A width of zero counts as one pixel: only column 0 is seen.
    '{1'b1, 0, 1'b1, 8'hFF, 1, 1'b1, 1'b1, '{1'b1, 13'd0, 12'd0, 13'd0, 13'd0, 12'd0, 12'd0}},
    '{1'b0, 0, 1'b1, 8'h7F, 1, 1'b1, 1'b1, NO_BOX},
    // Nine pixels wide: column 8 counts, column 9 is padding.
    '{1'b1, 9, 1'b1, 8'h00, 1, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b1, 8'hC0, 1, 1'b1, 1'b1, '{1'b1, 13'd8, 12'd0, 13'd8, 13'd8, 12'd0, 12'd0}},
    // One pixel wide rows are still four bytes long; the fifth byte is row 1.
    '{1'b1, 1, 1'b1, 8'h00, 4, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b1, 8'h80, 1, 1'b1, 1'b1, '{1'b1, 13'd0, 12'd1, 13'd0, 13'd0, 12'd1, 12'd1}},
    // Widest register value is clamped to the maximum width; last column.
    '{1'b1, 16383, 1'b1, 8'h00, 1023, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b1, 8'h01, 1, 1'b1, 1'b1,
      '{1'b1, 13'd8191, 12'd0, 13'd8191, 13'd8191, 12'd0, 12'd0}},
    // Narrowing the width in the middle of a long row closes that row on the
    // next byte, so the following byte lands at the start of row 1.
    '{1'b1, 8192, 1'b1, 8'h00, 20, 1'b0, 1'b0, NO_BOX},
    '{1'b1, 32, 1'b1, 8'h00, 1, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b1, 8'h80, 1, 1'b1, 1'b1, '{1'b1, 13'd0, 12'd1, 13'd0, 13'd0, 12'd1, 12'd1}},
    // A few rows of a narrow image, checked against the predictor.
    '{1'b1, 40, 1'b0, 8'h00, 9, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b0, 8'h30, 1, 1'b0, 1'b0, NO_BOX},
    '{1'b0, 0, 1'b0, 8'h06, 12, 1'b1, 1'b0, NO_BOX}
  };

  // Width in effect: zero acts as one, anything past the maximum as the maximum.
  function automatic int unsigned pixel_span();
    if (width_reg == 0) return 1;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return width_reg;
  endfunction

  // Stored row length in bytes: the width rounded up to whole 32-pixel words.
  function automatic int unsigned row_stride();
    return ((pixel_span() + ROW_PAD_PIX - 1) / ROW_PAD_PIX) * (ROW_PAD_PIX / PIX_W);
  endfunction

  // Folds one accepted pixel byte into the running box. Returns 1 when the
  // byte ends the frame, with the box the block must report in box.
  function automatic bit absorb_byte(input logic [PIX_W-1:0] pix, input logic fin,
                                     output box_t box);
    int unsigned span;
    int unsigned xpos;
    int unsigned bitsel;
    span = pixel_span();
    box = NO_BOX;
    for (int k = 0; k < PIX_W; k++) begin
      bitsel = msb_reg ? PIX_W - 1 - k : k;
      xpos = byte_col * PIX_W + k;
      if (pix[bitsel] && xpos < span) begin
        if (!white_seen) begin
          x_lo = xpos;
          x_hi = xpos;
          y_lo = row_num;
          y_hi = row_num;
          white_seen = 1'b1;
        end else begin
          if (xpos < x_lo) x_lo = xpos;
          if (xpos > x_hi) x_hi = xpos;
          if (row_num < y_lo) y_lo = row_num;
          if (row_num > y_hi) y_hi = row_num;
        end
      end
    end
    // The row also closes when a narrowed width leaves the column past its end.
    if (byte_col + 1 >= row_stride()) begin
      byte_col = 0;
      if (row_num < DEF_MAX_ROWS - 1) row_num++;
    end else begin
      byte_col++;
    end
    if (!fin) return 1'b0;
    if (white_seen) begin
      box.found     = 1'b1;
      box.mid_x     = X_OUT_W'((x_lo + x_hi) / 2);
      box.mid_y     = Y_OUT_W'((y_lo + y_hi) / 2);
      box.box_x_min = X_OUT_W'(x_lo);
      box.box_x_max = X_OUT_W'(x_hi);
      box.box_y_min = Y_OUT_W'(y_lo);
      box.box_y_max = Y_OUT_W'(y_hi);
    end
    byte_col = 0;
    row_num = 0;
    x_lo = 0;
    x_hi = 0;
    y_lo = 0;
    y_hi = 0;
    white_seen = 1'b0;
    return 1'b1;
  endfunction

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("binary_image_bbox_center test failed");
        $finish;
      end
    end
  end

  // Register write: one cycle with the write enable high.
  task automatic write_reg(input bbc_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Writes both registers and updates the shadow copy the predictor uses.
  task automatic program_regs(input int width, input bit msb);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
    width_reg = IMG_WIDTH_W'(width);
    write_reg(REG_MSB_FIRST, CFG_DATA_W'(msb));
    msb_reg = msb;
  endtask

  // Stops the pixel stream and waits until every expected box has been taken
  // and the last bytes have left the input register, so that a register
  // write cannot overtake a byte that is still in flight.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offers one byte and holds it until the block takes it. The expectation is
  // worked out at the transfer. Unless the sender is quiet, it then sometimes drops
  // valid before the next byte; otherwise valid is left high after a transfer so that
  // back-to-back bytes need no second assignment within the same step.
  task automatic send_byte(input logic [PIX_W-1:0] pix, input logic fin,
                           input bit fixed, input box_t fixed_box);
    box_t box;
    pix_if.valid      <= 1'b1;
    pix_if.pixel_byte <= pix;
    pix_if.frame_end  <= fin;
    do @(posedge clk); while (!pix_if.ready);
    if (absorb_byte(pix, fin, box)) boxes_due.push_back(fixed ? fixed_box : box);
    if (!sender_quiet && $urandom_range(0, 99) < 10) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Result receiver. Mostly ready, dropping ready with a chance of 13 in a
  // hundred. Once the random part has started it refuses results for a long
  // stretch, and then stays ready for a while with no gaps at all.
  initial begin
    bit holdoff_done;
    int quiet_left;
    holdoff_done = 1'b0;
    quiet_left = 0;
    box_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (holdoff_armed && !holdoff_done) begin
        box_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holdoff_done = 1'b1;
        quiet_left = QUIET_CYCLES;
      end else if (quiet_left > 0) begin
        box_if.ready <= 1'b1;
        quiet_left--;
      end else begin
        box_if.ready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Result checker: every result transfer is matched with the oldest
  // expected box, field by field.
  always @(posedge clk) begin
    box_t got;
    box_t want;
    if (!rst && box_if.valid && box_if.ready) begin
      got = '{box_if.found, box_if.mid_x, box_if.mid_y, box_if.box_x_min,
              box_if.box_x_max, box_if.box_y_min, box_if.box_y_max};
      if (boxes_due.size() == 0) begin
        $error("result transfer with no frame pending: found %0d center (%0d, %0d)",
               got.found, got.mid_x, got.mid_y);
        mismatches++;
      end else begin
        want = boxes_due.pop_front();
        if (got !== want) mismatches++;
        if (got.found !== want.found)
          $error("found: expected %0d, got %0d", want.found, got.found);
        if (got.mid_x !== want.mid_x)
          $error("mid_x: expected %0d, got %0d", want.mid_x, got.mid_x);
        if (got.mid_y !== want.mid_y)
          $error("mid_y: expected %0d, got %0d", want.mid_y, got.mid_y);
        if (got.box_x_min !== want.box_x_min)
          $error("box_x_min: expected %0d, got %0d", want.box_x_min, got.box_x_min);
        if (got.box_x_max !== want.box_x_max)
          $error("box_x_max: expected %0d, got %0d", want.box_x_max, got.box_x_max);
        if (got.box_y_min !== want.box_y_min)
          $error("box_y_min: expected %0d, got %0d", want.box_y_min, got.box_y_min);
        if (got.box_y_max !== want.box_y_max)
          $error("box_y_max: expected %0d, got %0d", want.box_y_max, got.box_y_max);
      end
    end
  end

  // Stimulus: reset, the directed plan, then random frames.
  initial begin
    int rand_sent;
    int frames_left;
    int frame_len;
    int len_cap;
    int mode;
    int sel;
    int width;
    bit cut;
    logic [PIX_W-1:0] pix;

    rand_sent = 0;
    frames_left = 0;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_IMAGE_WIDTH;
    cfg_wdata         <= '0;
    pix_if.valid      <= 1'b0;
    pix_if.pixel_byte <= '0;
    pix_if.frame_end  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Registers are only rewritten once the block is idle,
    // which may still be in the middle of a frame.
    foreach (plan[i]) begin
      if (plan[i].set_cfg) begin
        settle();
        program_regs(plan[i].width, plan[i].msb);
      end
      for (int r = 0; r < plan[i].reps; r++)
        send_byte(plan[i].pix, plan[i].fin && (r == plan[i].reps - 1),
                  plan[i].fixed, plan[i].box);
    end

    // Random part: phases of a few frames each under one configuration.
    // Now and then a phase stops in the middle of a frame, so the next
    // configuration lands mid-frame.
    while (rand_sent < RANDOM_ITEMS) begin
      if (frames_left == 0) begin
        settle();
        // Mostly narrow images so that frames span several rows; sometimes
        // wide ones, widths past the maximum, and zero.
        sel = $urandom_range(0, 99);
        if (sel < 45) width = $urandom_range(1, 64);
        else if (sel < 80) width = $urandom_range(65, 400);
        else if (sel < 90) width = $urandom_range(401, DEF_MAX_WIDTH);
        else if (sel < 95) width = $urandom_range(DEF_MAX_WIDTH + 1, 16383);
        else width = 0;
        program_regs(width, $urandom_range(0, 1));
        frames_left = $urandom_range(2, 8);
        // The long hold-off starts once the first random phase is configured, so the
        // sender keeps offering bytes behind the blocked result.
        holdoff_armed = 1'b1;
      end
      len_cap = row_stride() * 3 + 2;
      if (len_cap > 80) len_cap = 80;
      frame_len = $urandom_range(1, len_cap);
      // Blank frames, sparse single pixels, or dense random bytes.
      mode = $urandom_range(0, 9);
      cut = ($urandom_range(0, 99) < 8);
      for (int j = 0; j < frame_len; j++) begin
        if (mode == 0) begin
          pix = '0;
        end else if (mode < 5) begin
          pix = ($urandom_range(0, 15) == 0) ? PIX_W'(1) << $urandom_range(0, 7) : '0;
        end else begin
          pix = ($urandom_range(0, 7) == 0) ? '1 : PIX_W'($urandom_range(0, 255));
        end
        // A long run of random bytes with no sender gaps.
        sender_quiet = (rand_sent >= 300 && rand_sent < 600);
        send_byte(pix, (j == frame_len - 1) && !cut, 1'b0, NO_BOX);
        rand_sent++;
      end
      frames_left = cut ? 0 : frames_left - 1;
    end

    // Let the last results come out, then allow for the pipeline latency.
    pix_if.valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (mismatches == 0)
      $display("binary_image_bbox_center test passed");
    else
      $display("binary_image_bbox_center test failed");
    $finish;
  end

endmodule

### filelist.f
hdl/bbc_pkg.sv
hdl/bbc_in_if.sv
hdl/bbc_out_if.sv
hdl/bbc_pixel_scan.sv
hdl/bbc_box_track.sv
hdl/binary_image_bbox_center.sv
tb/sv/tb_top.sv
